### src/h3fd_pkg.sv
package h3fd_pkg;

	localparam int unsigned VARINT_W = 62;

	localparam logic [5:0] VARINT_HEAD_MASK = 6'h3F;

	typedef enum logic [1:0] {
		PH_TYPE = 2'd0,
		PH_LEN  = 2'd1,
		PH_PAY  = 2'd2
	} phase_t;

	localparam logic [1:0] KIND_DATA    = 2'd0;
	localparam logic [1:0] KIND_HEADERS = 2'd1;
	localparam logic [1:0] KIND_UNKNOWN = 2'd2;

	localparam logic [1:0] ST_OK            = 2'd0;
	localparam logic [1:0] ST_TRUNC_PAYLOAD = 2'd1;
	localparam logic [1:0] ST_TRUNC_VARINT  = 2'd2;

	typedef logic [VARINT_W-1:0] varint_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [1:0] frame_kind;
		varint_t    frame_type;
		logic       frame_end;
		logic       end_of_stream;
		logic [1:0] end_status;
	} result_t;

	function automatic logic [1:0] kind_of(input varint_t t);
		logic [1:0] k;
		if (t == varint_t'(0)) begin
			k = KIND_DATA;
		end else if (t == varint_t'(1)) begin
			k = KIND_HEADERS;
		end else begin
			k = KIND_UNKNOWN;
		end
		return k;
	endfunction

	// bytes after the first one, from the two size bits
	function automatic logic [2:0] varint_extra(input logic [1:0] sz);
		logic [2:0] n;
		case (sz)
			2'd0: n = 3'd0;
			2'd1: n = 3'd1;
			2'd2: n = 3'd3;
			2'd3: n = 3'd7;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

### src/h3fd_parser.sv
module h3fd_parser
	import h3fd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       emit,
	output result_t    res
);

	phase_t     phase_q, phase_p, phase_d;
	logic [2:0] left_q, left_p, left_d;
	varint_t    acc_q, acc_p, acc_d;
	varint_t    type_q, type_p, type_d;
	varint_t    rem_q, rem_p, rem_d;

	logic [2:0] feed_left;
	varint_t    feed_acc;
	logic       feed_done;
	varint_t    rem_dec;
	logic       rem_zero;
	logic [1:0] kind_cur;

	always_comb begin
		if (left_q == 3'd0) begin
			feed_acc  = {{(VARINT_W-6){1'b0}}, in_byte[5:0] & VARINT_HEAD_MASK};
			feed_left = varint_extra(in_byte[7:6]);
		end else begin
			feed_acc  = {acc_q[VARINT_W-9:0], in_byte};
			feed_left = left_q - 3'd1;
		end
	end

	assign feed_done = (feed_left == 3'd0);
	assign rem_dec   = rem_q - varint_t'(1);
	assign rem_zero  = (rem_dec == varint_t'(0));
	assign kind_cur  = kind_of(type_q);

	// next state
	always_comb begin
		phase_p = phase_q;
		left_p  = left_q;
		acc_p   = acc_q;
		type_p  = type_q;
		rem_p   = rem_q;
		case (phase_q)
			PH_PAY: begin
				rem_p = rem_dec;
				if (rem_zero) begin
					phase_p = PH_TYPE;
				end
			end
			PH_LEN: begin
				left_p = feed_left;
				acc_p  = feed_acc;
				if (feed_done) begin
					rem_p = feed_acc;
					acc_p = '0;
					if (feed_acc == varint_t'(0)) begin
						phase_p = PH_TYPE;
					end else begin
						phase_p = PH_PAY;
					end
				end
			end
			PH_TYPE: begin
				left_p = feed_left;
				acc_p  = feed_acc;
				if (feed_done) begin
					type_p  = feed_acc;
					acc_p   = '0;
					phase_p = PH_LEN;
				end
			end
			default: begin
				phase_p = PH_TYPE;
			end
		endcase

		if (in_last) begin
			phase_d = PH_TYPE;
			left_d  = '0;
			acc_d   = '0;
			type_d  = '0;
			rem_d   = '0;
		end else begin
			phase_d = phase_p;
			left_d  = left_p;
			acc_d   = acc_p;
			type_d  = type_p;
			rem_d   = rem_p;
		end
	end

	// outputs
	always_comb begin
		emit = 1'b0;
		res  = '0;
		case (phase_q)
			PH_PAY: begin
				if (kind_cur != KIND_UNKNOWN) begin
					emit              = 1'b1;
					res.payload_byte  = in_byte;
					res.payload_valid = 1'b1;
				end
				if (rem_zero) begin
					emit          = 1'b1;
					res.frame_end = 1'b1;
				end
				if (emit) begin
					res.frame_kind = kind_cur;
					res.frame_type = type_q;
				end
			end
			PH_LEN: begin
				if (feed_done && feed_acc == varint_t'(0)) begin
					emit           = 1'b1;
					res.frame_end  = 1'b1;
					res.frame_kind = kind_cur;
					res.frame_type = type_q;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase

		if (in_last) begin
			emit              = 1'b1;
			res.end_of_stream = 1'b1;
			if (phase_p == PH_TYPE && left_p == 3'd0) begin
				res.end_status = ST_OK;
			end else if (phase_p == PH_PAY) begin
				res.end_status = ST_TRUNC_PAYLOAD;
			end else begin
				res.end_status = ST_TRUNC_VARINT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			left_q  <= '0;
			acc_q   <= '0;
			type_q  <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			type_q  <= type_d;
			rem_q   <= rem_d;
		end
	end

endmodule

### src/http3_frame_deframer_core.sv
// Takes one stream byte per clock unless held off, and gives at most one result per
// byte, held first in the input register and then in the result register. Type
// and length varints, payload counting and stream-end status are worked out in
// a single pass between those two registers, so a byte can be
// accepted every cycle; input is held off only while the result register holds a
// transaction that the consumer has not yet taken. Bytes that give no result
// (varint bytes, skipped payload) leave no trace on the output.
module http3_frame_deframer_core
	import h3fd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] payload_byte,
	output logic       payload_valid,
	output logic [1:0] frame_kind,
	output varint_t    frame_type,
	output logic       frame_end,
	output logic       end_of_stream,
	output logic [1:0] end_status
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	logic       emit;
	result_t    res;
	logic       out_valid_q;
	result_t    res_q;

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			last_s1 <= stream_end;
		end
	end

	h3fd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = res_q.payload_byte;
	assign payload_valid = res_q.payload_valid;
	assign frame_kind    = res_q.frame_kind;
	assign frame_type    = res_q.frame_type;
	assign frame_end     = res_q.frame_end;
	assign end_of_stream = res_q.end_of_stream;
	assign end_status    = res_q.end_status;

endmodule

### src/h3fd_checker.sv
module h3fd_checker
	import h3fd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] payload_byte,
	input logic       payload_valid,
	input logic [1:0] frame_kind,
	input varint_t    frame_type,
	input logic       frame_end,
	input logic       end_of_stream,
	input logic [1:0] end_status
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_byte)
			&& $stable(frame_type) && $stable(end_status))
		else $error("result changed while stalled");

	// skipped payload never shows on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && payload_valid |-> frame_kind == KIND_DATA || frame_kind == KIND_HEADERS)
		else $error("payload from unknown frame type");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid |-> payload_byte == 8'd0)
		else $error("payload byte without payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_stream |-> end_status == ST_OK)
		else $error("status outside stream end");

	// a bare stream end carries no frame content
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !payload_valid && !frame_end
			|-> end_of_stream && frame_kind == KIND_DATA && frame_type == '0)
		else $error("empty result with frame content");

endmodule

bind http3_frame_deframer_core h3fd_checker u_h3fd_checker (.*);

### bench/http3_frame_deframer_core_tb.sv
module http3_frame_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import h3fd_pkg::*;

	typedef logic [7:0] octet_q_t [$];

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_in;
	logic       stream_end;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic [1:0] frame_kind;
	varint_t    frame_type;
	logic       frame_end;
	logic       end_of_stream;
	logic [1:0] end_status;

	int in_idle_pct = 29;
	int out_idle_pct = 71;
	int errors = 0;
	int bytes_sent = 0;

	// parser state mirror
	phase_t     prs_phase;
	logic [2:0] vint_left;
	varint_t    vint_acc;
	varint_t    frm_type;
	varint_t    pay_left;

	result_t expected_results [$];
	result_t want;

	http3_frame_deframer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_in      (byte_in),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.frame_kind   (frame_kind),
		.frame_type   (frame_type),
		.frame_end    (frame_end),
		.end_of_stream(end_of_stream),
		.end_status   (end_status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [1:0] frame_kind_of(input varint_t t);
		if (t == varint_t'(0))
			return KIND_DATA;
		if (t == varint_t'(1))
			return KIND_HEADERS;
		return KIND_UNKNOWN;
	endfunction

	task automatic clear_parser();
		prs_phase = PH_TYPE;
		vint_left = 3'd0;
		vint_acc = '0;
		frm_type = '0;
		pay_left = '0;
	endtask

	task automatic take_varint_byte(input logic [7:0] b, output logic done);
		if (vint_left == 3'd0) begin
			vint_acc = varint_t'(b[5:0] & VARINT_HEAD_MASK);
			vint_left = 3'((4'd1 << b[7:6]) - 4'd1);
		end else begin
			vint_acc = {vint_acc[VARINT_W-9:0], b};
			vint_left = vint_left - 3'd1;
		end
		done = (vint_left == 3'd0);
	endtask

	// expected result of one stream byte, if any
	task automatic deframe_byte(input logic [7:0] b, input logic is_last);
		result_t r;
		logic have;
		logic done;
		logic [1:0] k;
		r = '0;
		have = 1'b0;
		case (prs_phase)
			PH_PAY: begin
				k = frame_kind_of(frm_type);
				pay_left = pay_left - varint_t'(1);
				if (k != KIND_UNKNOWN) begin
					have = 1'b1;
					r.payload_byte = b;
					r.payload_valid = 1'b1;
				end
				if (pay_left == '0) begin
					have = 1'b1;
					r.frame_end = 1'b1;
					prs_phase = PH_TYPE;
				end
				if (have) begin
					r.frame_kind = k;
					r.frame_type = frm_type;
				end
			end
			PH_LEN: begin
				take_varint_byte(b, done);
				if (done) begin
					pay_left = vint_acc;
					vint_acc = '0;
					if (pay_left == '0) begin
						have = 1'b1;
						r.frame_end = 1'b1;
						r.frame_kind = frame_kind_of(frm_type);
						r.frame_type = frm_type;
						prs_phase = PH_TYPE;
					end else begin
						prs_phase = PH_PAY;
					end
				end
			end
			default: begin
				take_varint_byte(b, done);
				if (done) begin
					frm_type = vint_acc;
					vint_acc = '0;
					prs_phase = PH_LEN;
				end
			end
		endcase
		if (is_last) begin
			have = 1'b1;
			r.end_of_stream = 1'b1;
			if (prs_phase == PH_TYPE && vint_left == 3'd0)
				r.end_status = ST_OK;
			else if (prs_phase == PH_PAY)
				r.end_status = ST_TRUNC_PAYLOAD;
			else
				r.end_status = ST_TRUNC_VARINT;
			clear_parser();
		end
		if (have)
			expected_results.push_back(r);
	endtask

	task automatic report_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: expected none actual byte %0h end %0b eos %0b",
					$time, payload_byte, frame_end, end_of_stream);
			end else begin
				want = expected_results.pop_front();
				report_field("payload_byte", 64'(want.payload_byte), 64'(payload_byte));
				report_field("payload_valid", 64'(want.payload_valid), 64'(payload_valid));
				report_field("frame_kind", 64'(want.frame_kind), 64'(frame_kind));
				report_field("frame_type", 64'(want.frame_type), 64'(frame_type));
				report_field("frame_end", 64'(want.frame_end), 64'(frame_end));
				report_field("end_of_stream", 64'(want.end_of_stream), 64'(end_of_stream));
				report_field("end_status", 64'(want.end_status), 64'(end_status));
			end
		end
	end

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= out_idle_pct);

	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		stream_end <= is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		deframe_byte(b, is_last);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_seq(input octet_q_t q, input logic end_at_last);
		foreach (q[i])
			send_byte(q[i], end_at_last && (i == q.size() - 1));
	endtask

	// sender stays idle until every expected result has come
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_results.size() != 0);
	endtask

	// encodes v with its shortest size, sometimes a longer one
	task automatic put_varint(input varint_t v, input logic force_long, ref octet_q_t q);
		int mc;
		int c;
		int n;
		logic [63:0] w;
		if (v < 64'd64)
			mc = 0;
		else if (v < (64'd1 << 14))
			mc = 1;
		else if (v < (64'd1 << 30))
			mc = 2;
		else
			mc = 3;
		c = (force_long || $urandom_range(3) == 0) ? $urandom_range(3, mc) : mc;
		n = 1 << c;
		w = (64'(c) << (8 * n - 2)) | 64'(v);
		for (int i = n - 1; i >= 0; i--)
			q.push_back(w[8 * i +: 8]);
	endtask

	function automatic varint_t pick_type();
		int r;
		r = $urandom_range(9);
		if (r <= 3)
			return varint_t'(0);
		if (r <= 6)
			return varint_t'(1);
		if (r == 7)
			return varint_t'($urandom_range(63, 2));
		if (r == 8)
			return varint_t'($urandom_range(16383, 2));
		return varint_t'({$urandom, $urandom}) | varint_t'(2);
	endfunction

	task automatic build_frame(ref octet_q_t q);
		int len;
		len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6);
		put_varint(pick_type(), 1'b0, q);
		put_varint(varint_t'(len), 1'b0, q);
		repeat (len)
			q.push_back(8'($urandom_range(255)));
	endtask

	task automatic test_frame_kinds();
		send_seq('{8'h00, 8'h00}, 1'b0);
		send_seq('{8'h01, 8'h02, 8'hAA, 8'h55}, 1'b0);
		send_seq('{8'h7F, 8'hFF, 8'h02, 8'h00, 8'hFF}, 1'b0);
	endtask

	task automatic test_varint_extremes();
		// largest 8-byte type, zero length in four bytes
		send_seq('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h80, 8'h00, 8'h00, 8'h00}, 1'b0);
	endtask

	task automatic test_stream_end_status();
		send_seq('{8'h00, 8'h40, 8'h05, 8'h80}, 1'b1);
		send_seq('{8'h40}, 1'b1);
		send_seq('{8'h01, 8'h00}, 1'b1);
	endtask

	task automatic test_random_streams(input int n_bytes);
		octet_q_t q;
		int target;
		int r;
		int cut;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			q = {};
			r = $urandom_range(19);
			if ($urandom_range(39) == 0)
				wait_drained();
			if (r == 0) begin
				repeat ($urandom_range(6, 1))
					q.push_back(8'($urandom_range(255)));
				send_seq(q, 1'b1);
			end else if (r == 1) begin
				// huge length, cut off inside the payload
				put_varint(pick_type(), 1'b0, q);
				put_varint(varint_t'({$urandom, $urandom}) | (varint_t'(1) << 40), 1'b1, q);
				repeat ($urandom_range(5, 1))
					q.push_back(8'($urandom_range(255)));
				send_seq(q, 1'b1);
			end else begin
				repeat ($urandom_range(4, 1))
					build_frame(q);
				if ($urandom_range(3) == 0) begin
					cut = $urandom_range(q.size(), 1);
					q = q[0:cut-1];
				end
				send_seq(q, 1'b1);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		byte_in = 8'h00;
		stream_end = 1'b0;
		out_ready = 1'b0;
		clear_parser();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_frame_kinds();
		test_varint_extremes();
		test_stream_end_status();
		test_random_streams(500);
		wait_drained();

		in_idle_pct = 71;
		out_idle_pct = 29;
		test_random_streams(500);
		wait_drained();

		in_idle_pct = 0;
		out_idle_pct = 0;
		test_random_streams(500);

		wait_drained();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
src/h3fd_pkg.sv
src/h3fd_parser.sv
src/http3_frame_deframer_core.sv
src/h3fd_checker.sv
bench/http3_frame_deframer_core_tb.sv
